[rtl/cbgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbgd_pkg
// Shared types, codes and denomination helpers for the coin bank dispenser.
// ----------------------------------------------------------------------------
package cbgd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int NUM_DEN   = 5;
  localparam int AMT_W     = 24;
  localparam int COIN_W    = 8;
  localparam int TAKE_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int DEN_VAL_W = 7;

  typedef logic [2:0] den_idx_t;

  // denomination order, largest first
  localparam den_idx_t DEN_100 = 3'd0;
  localparam den_idx_t DEN_50  = 3'd1;
  localparam den_idx_t DEN_25  = 3'd2;
  localparam den_idx_t DEN_10  = 3'd3;
  localparam den_idx_t DEN_5   = 3'd4;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_DEPOSITED  = 3'd0;
  localparam status_t ST_UNKNOWN    = 3'd1;
  localparam status_t ST_FULL       = 3'd2;
  localparam status_t ST_WITHDRAWN  = 3'd3;
  localparam status_t ST_NO_BALANCE = 3'd4;
  localparam status_t ST_NO_COINS   = 3'd5;

  typedef enum logic [1:0] {
    OP_DEPOSIT  = 2'd0,
    OP_UNKNOWN  = 2'd1,
    OP_WITHDRAW = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    den_idx_t         coin_idx;
    logic [AMT_W-1:0] amount;
  } entry_t;

  // floor(x/5) and floor(x/25) by reciprocal, exact for any 24-bit x
  localparam logic [24:0] RECIP_5   = 25'd13421773;
  localparam int          SHIFT_5   = 26;
  localparam logic [24:0] RECIP_25  = 25'd21474837;
  localparam int          SHIFT_25  = 29;

  function automatic logic [DEN_VAL_W-1:0] den_value(input den_idx_t k);
    logic [DEN_VAL_W-1:0] v;
    case (k)
      DEN_100: v = 7'd100;
      DEN_50:  v = 7'd50;
      DEN_25:  v = 7'd25;
      DEN_10:  v = 7'd10;
      DEN_5:   v = 7'd5;
      default: v = 7'd5;
    endcase
    return v;
  endfunction

  function automatic logic [AMT_W-1:0] div_den(input logic [AMT_W-1:0] x,
                                               input den_idx_t k);
    logic [AMT_W-1:0] opnd;
    logic [24:0]      recip;
    logic [48:0]      prod;
    logic [AMT_W-1:0] q;
    case (k)
      DEN_100: begin
        opnd  = x >> 2;
        recip = RECIP_25;
      end
      DEN_50: begin
        opnd  = x >> 1;
        recip = RECIP_25;
      end
      DEN_25: begin
        opnd  = x;
        recip = RECIP_25;
      end
      DEN_10: begin
        opnd  = x >> 1;
        recip = RECIP_5;
      end
      default: begin
        opnd  = x;
        recip = RECIP_5;
      end
    endcase
    prod = 49'(opnd) * 49'(recip);
    if (k == DEN_100 || k == DEN_50 || k == DEN_25) begin
      q = AMT_W'(prod >> SHIFT_25);
    end else begin
      q = AMT_W'(prod >> SHIFT_5);
    end
    return q;
  endfunction

  function automatic logic [AMT_W-1:0] mul_den(input logic [AMT_W-1:0] n,
                                               input den_idx_t k);
    logic [AMT_W+DEN_VAL_W-1:0] p;
    p = (AMT_W+DEN_VAL_W)'(n) * (AMT_W+DEN_VAL_W)'(den_value(k));
    return p[AMT_W-1:0];
  endfunction

endpackage

[rtl/cbgd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbgd_front
// Input stage: takes items, decodes the operation and coin, feeds the queue.
// ----------------------------------------------------------------------------
module cbgd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [cbgd_pkg::COIN_W-1:0] in_coin_cents,
  input  logic [cbgd_pkg::AMT_W-1:0]  in_amount_cents,
  output logic                        push,
  output cbgd_pkg::entry_t            push_data,
  input  logic                        q_full
);
  import cbgd_pkg::*;

  logic   fr_valid_r, fr_valid_nxt;
  entry_t fr_data_r;
  entry_t cls;
  logic   accept;

  assign in_stall  = fr_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = fr_valid_r && !q_full;
  assign push_data = fr_data_r;

  always_comb begin
    cls.amount   = in_amount_cents;
    cls.coin_idx = DEN_5;
    cls.op       = OP_DEPOSIT;
    if (in_func) begin
      cls.op = OP_WITHDRAW;
    end else begin
      case (in_coin_cents)
        8'd100:  cls.coin_idx = DEN_100;
        8'd50:   cls.coin_idx = DEN_50;
        8'd25:   cls.coin_idx = DEN_25;
        8'd10:   cls.coin_idx = DEN_10;
        8'd5:    cls.coin_idx = DEN_5;
        default: cls.op       = OP_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_data_r <= cls;
    end
  end

endmodule

[rtl/cbgd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbgd_queue
// Small queue of decoded items between the input stage and the executor.
// ----------------------------------------------------------------------------
module cbgd_queue #(
  parameter int DEPTH = cbgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cbgd_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output cbgd_pkg::entry_t pop_data,
  output logic             empty
);
  import cbgd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/cbgd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbgd_back
// Executor: holds the coin counters and balance, runs deposits in one step
// and withdrawals as a greedy walk over the denominations.
// ----------------------------------------------------------------------------
module cbgd_back #(
  parameter int COUNT_WIDTH = cbgd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  cbgd_pkg::entry_t              q_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cbgd_pkg::STATUS_W-1:0] out_status,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_100,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_50,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_25,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_10,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_5,
  output logic [cbgd_pkg::AMT_W-1:0]    out_balance_cents
);
  import cbgd_pkg::*;

  localparam int BAL_W = (COUNT_WIDTH + 8 > AMT_W) ? COUNT_WIDTH + 8 : AMT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SUB  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_DEN];
  logic [COUNT_WIDTH-1:0] cnt_nxt [NUM_DEN];
  logic [BAL_W-1:0]       bal_r, bal_nxt;
  den_idx_t               k_r, k_nxt;
  logic [AMT_W-1:0]       rem_r, rem_nxt;
  logic [AMT_W-1:0]       amt_r;
  logic [AMT_W-1:0]       q_r;
  logic [AMT_W-1:0]       take_r [NUM_DEN];

  logic                   ov_r, ov_nxt;
  status_t                st_r, st_nxt;
  logic [TAKE_W-1:0]      ot_r [NUM_DEN];
  logic [TAKE_W-1:0]      ot_nxt [NUM_DEN];
  logic [AMT_W-1:0]       ob_r, ob_nxt;

  logic                   out_ready;
  den_idx_t               rd_idx;
  logic [COUNT_WIDTH-1:0] have;
  logic [AMT_W-1:0]       have_w;
  logic [AMT_W-1:0]       n_sel;
  logic                   latch_wd;

  assign out_ready = !ov_r || !out_stall;
  assign rd_idx    = (state_r == S_IDLE) ? q_data.coin_idx : k_r;
  assign have      = cnt_r[rd_idx];
  assign have_w    = AMT_W'(have);
  assign n_sel     = (q_r > have_w) ? have_w : q_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    bal_nxt   = bal_r;
    pop       = 1'b0;
    latch_wd  = 1'b0;
    ov_nxt    = ov_r && out_stall;
    st_nxt    = st_r;
    ob_nxt    = ob_r;
    for (int i = 0; i < NUM_DEN; i++) begin
      cnt_nxt[i] = cnt_r[i];
      ot_nxt[i]  = ot_r[i];
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty && out_ready) begin
          pop = 1'b1;
          case (q_data.op)
            OP_DEPOSIT: begin
              ov_nxt = 1'b1;
              for (int i = 0; i < NUM_DEN; i++) ot_nxt[i] = '0;
              if (have == {COUNT_WIDTH{1'b1}}) begin
                st_nxt = ST_FULL;
              end else begin
                st_nxt                  = ST_DEPOSITED;
                cnt_nxt[q_data.coin_idx] = have + 1'b1;
                bal_nxt = bal_r + BAL_W'(den_value(q_data.coin_idx));
              end
              ob_nxt = bal_nxt[AMT_W-1:0];
            end
            OP_WITHDRAW: begin
              if (bal_r < BAL_W'(q_data.amount)) begin
                ov_nxt = 1'b1;
                st_nxt = ST_NO_BALANCE;
                for (int i = 0; i < NUM_DEN; i++) ot_nxt[i] = '0;
                ob_nxt = bal_r[AMT_W-1:0];
              end else begin
                latch_wd  = 1'b1;
                rem_nxt   = q_data.amount;
                k_nxt     = DEN_100;
                state_nxt = S_DIV;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              st_nxt = ST_UNKNOWN;
              for (int i = 0; i < NUM_DEN; i++) ot_nxt[i] = '0;
              ob_nxt = bal_r[AMT_W-1:0];
            end
          endcase
        end
      end
      S_DIV: begin
        state_nxt = S_SUB;
      end
      S_SUB: begin
        rem_nxt = rem_r - mul_den(n_sel, k_r);
        if (k_r == DEN_5) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_FIN: begin
        if (out_ready) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (rem_r == '0) begin
            st_nxt  = ST_WITHDRAWN;
            bal_nxt = bal_r - BAL_W'(amt_r);
            for (int i = 0; i < NUM_DEN; i++) begin
              cnt_nxt[i] = cnt_r[i] - COUNT_WIDTH'(take_r[i]);
              ot_nxt[i]  = take_r[i][TAKE_W-1:0];
            end
          end else begin
            st_nxt = ST_NO_COINS;
            for (int i = 0; i < NUM_DEN; i++) ot_nxt[i] = '0;
          end
          ob_nxt = bal_nxt[AMT_W-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      bal_r   <= '0;
      k_r     <= DEN_100;
      for (int i = 0; i < NUM_DEN; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      bal_r   <= bal_nxt;
      k_r     <= k_nxt;
      for (int i = 0; i < NUM_DEN; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    st_r  <= st_nxt;
    ob_r  <= ob_nxt;
    for (int i = 0; i < NUM_DEN; i++) ot_r[i] <= ot_nxt[i];
    if (latch_wd) begin
      amt_r <= q_data.amount;
    end
    if (state_r == S_DIV) begin
      q_r <= div_den(rem_r, k_r);
    end
    if (state_r == S_SUB) begin
      take_r[k_r] <= n_sel;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = st_r;
  assign out_100           = ot_r[DEN_100];
  assign out_50            = ot_r[DEN_50];
  assign out_25            = ot_r[DEN_25];
  assign out_10            = ot_r[DEN_10];
  assign out_5             = ot_r[DEN_5];
  assign out_balance_cents = ob_r;

endmodule

[rtl/coin_bank_greedy_dispenser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_bank_greedy_dispenser_core
// Coin bank holding five coin counters; deposits one coin per item and pays
// out withdrawals by greedy change-making limited by stock.
//
// Input channel (in_valid / in_stall): in_func selects deposit (0) or
// withdraw (1); in_coin_cents names the coin, in_amount_cents the amount.
// Result channel (out_valid / out_stall): one result per item with the
// status, dispensed coin counts and the balance after the item.
// An input stage decodes items into a queue; the executor drains it.
// Deposits and refused items finish in the executor's idle state at one item
// per cycle while out_stall is low; the first result passes the input
// register, the queue and the result register. Withdrawals that pass the
// balance check: entry, per denomination reciprocal multiply then limit and
// subtract, then commit, on the single shared divide-by-constant multiplier.
// Reset clears all counters and the balance to zero and empties the queue.
// While out_stall is high the result is held; the queue keeps accepting
// items until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module coin_bank_greedy_dispenser_core #(
  parameter int COUNT_WIDTH = cbgd_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = cbgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [cbgd_pkg::COIN_W-1:0]   in_coin_cents,
  input  logic [cbgd_pkg::AMT_W-1:0]    in_amount_cents,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cbgd_pkg::STATUS_W-1:0] out_status,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_100,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_50,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_25,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_10,
  output logic [cbgd_pkg::TAKE_W-1:0]   out_5,
  output logic [cbgd_pkg::AMT_W-1:0]    out_balance_cents
);
  import cbgd_pkg::*;

  logic   push, q_full, pop, q_empty;
  entry_t push_data, q_data;

  cbgd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_coin_cents   (in_coin_cents),
    .in_amount_cents (in_amount_cents),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  cbgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  cbgd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_100           (out_100),
    .out_50            (out_50),
    .out_25            (out_25),
    .out_10            (out_10),
    .out_5             (out_5),
    .out_balance_cents (out_balance_cents)
  );

endmodule

[tb/cbgd_payout_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbgd_payout_checker
// Watches both channels of the coin bank dispenser. On every input transfer
// it settles the item against its own copy of the five coin counters and
// queues the expected payout; every result transfer is compared field by
// field with the oldest queued payout. Reports mismatches and the number of
// payouts still outstanding.
// ----------------------------------------------------------------------------
module cbgd_payout_checker import cbgd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_func,
  input  logic [COIN_W-1:0]   in_coin_cents,
  input  logic [AMT_W-1:0]    in_amount_cents,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [TAKE_W-1:0]   out_100,
  input  logic [TAKE_W-1:0]   out_50,
  input  logic [TAKE_W-1:0]   out_25,
  input  logic [TAKE_W-1:0]   out_10,
  input  logic [TAKE_W-1:0]   out_5,
  input  logic [AMT_W-1:0]    out_balance_cents,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    status_t                        status;
    logic [NUM_DEN-1:0][TAKE_W-1:0] take;
    logic [AMT_W-1:0]               balance;
  } payout_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;

  logic [COUNT_WIDTH-1:0] coins [NUM_DEN];
  payout_t                payout_q [$];

  function automatic int coin_worth(input den_idx_t k);
    int v;
    case (k)
      DEN_100: v = 100;
      DEN_50:  v = 50;
      DEN_25:  v = 25;
      DEN_10:  v = 10;
      default: v = 5;
    endcase
    return v;
  endfunction

  function automatic longint held_cents();
    longint sum;
    sum = 0;
    for (int k = 0; k < NUM_DEN; k++) begin
      sum += longint'(coins[k]) * coin_worth(den_idx_t'(k));
    end
    return sum;
  endfunction

  function automatic payout_t settle(input logic func, input logic [COIN_W-1:0] coin,
                                     input logic [AMT_W-1:0] amount);
    payout_t r;
    longint  rem;
    longint  n;
    longint  want [NUM_DEN];
    longint  bal;
    int      slot;
    r    = '0;
    slot = -1;
    if (!func) begin
      for (int k = 0; k < NUM_DEN; k++) begin
        if (int'(coin) == coin_worth(den_idx_t'(k))) slot = k;
      end
      if (slot < 0) begin
        r.status = ST_UNKNOWN;
      end else if (coins[slot] == CNT_FULL) begin
        r.status = ST_FULL;
      end else begin
        coins[slot] = coins[slot] + 1'b1;
        r.status = ST_DEPOSITED;
      end
    end else if (held_cents() < longint'(amount)) begin
      r.status = ST_NO_BALANCE;
    end else begin
      rem = longint'(amount);
      for (int k = 0; k < NUM_DEN; k++) begin
        n = rem / coin_worth(den_idx_t'(k));
        if (n > longint'(coins[k])) n = longint'(coins[k]);
        want[k] = n;
        rem -= n * coin_worth(den_idx_t'(k));
      end
      if (rem == 0) begin
        for (int k = 0; k < NUM_DEN; k++) begin
          coins[k]  = coins[k] - want[k][COUNT_WIDTH-1:0];
          r.take[k] = want[k][TAKE_W-1:0];
        end
        r.status = ST_WITHDRAWN;
      end else begin
        r.status = ST_NO_COINS;
      end
    end
    bal = held_cents();
    r.balance = bal[AMT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    payout_t due;
    if (!rst_n) begin
      for (int k = 0; k < NUM_DEN; k++) coins[k] = '0;
      payout_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (payout_q.size() == 0) begin
          $error("result transfer with no payout outstanding");
          fail_count++;
        end else begin
          due = payout_q.pop_front();
          check_field("status", due.status, out_status);
          check_field("out_100", due.take[DEN_100], out_100);
          check_field("out_50", due.take[DEN_50], out_50);
          check_field("out_25", due.take[DEN_25], out_25);
          check_field("out_10", due.take[DEN_10], out_10);
          check_field("out_5", due.take[DEN_5], out_5);
          check_field("balance_cents", due.balance, out_balance_cents);
        end
      end
      if (in_valid && !in_stall) begin
        payout_q.push_back(settle(in_func, in_coin_cents, in_amount_cents));
      end
      pending <= payout_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the coin bank dispenser. Runs directed deposits and
// withdrawals on an empty and a lightly stocked bank, then a long random mix
// with bursts of idling on both channels.
// Checking is done by the payout checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import cbgd_pkg::*;

  localparam int CW           = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1025;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 1000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_func;
  logic [COIN_W-1:0]   in_coin_cents;
  logic [AMT_W-1:0]    in_amount_cents;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAKE_W-1:0]   out_100;
  logic [TAKE_W-1:0]   out_50;
  logic [TAKE_W-1:0]   out_25;
  logic [TAKE_W-1:0]   out_10;
  logic [TAKE_W-1:0]   out_5;
  logic [AMT_W-1:0]    out_balance_cents;

  int mismatches;
  int pending;
  int quiet_cycles;
  int stall_left;
  bit idle_on;

  coin_bank_greedy_dispenser_core #(.COUNT_WIDTH(CW)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_coin_cents     (in_coin_cents),
    .in_amount_cents   (in_amount_cents),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_100           (out_100),
    .out_50            (out_50),
    .out_25            (out_25),
    .out_10            (out_10),
    .out_5             (out_5),
    .out_balance_cents (out_balance_cents)
  );

  cbgd_payout_checker #(.COUNT_WIDTH(CW)) payout_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_coin_cents     (in_coin_cents),
    .in_amount_cents   (in_amount_cents),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_100           (out_100),
    .out_50            (out_50),
    .out_25            (out_25),
    .out_10            (out_10),
    .out_5             (out_5),
    .out_balance_cents (out_balance_cents),
    .fail_count        (mismatches),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // random receiver stall bursts
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int coin_pick();
    int v;
    case ($urandom_range(0, 4))
      0:       v = 100;
      1:       v = 50;
      2:       v = 25;
      3:       v = 10;
      default: v = 5;
    endcase
    return v;
  endfunction

  task automatic push_item(input logic func, input logic [COIN_W-1:0] coin,
                           input logic [AMT_W-1:0] amount);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_coin_cents   <= coin;
    in_amount_cents <= amount;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = 1'b0;
    in_coin_cents   = '0;
    in_amount_cents = '0;
    idle_on         = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bank: zero withdrawal succeeds, a nonzero one is refused
    push_item(1'b1, COIN_W'($urandom), '0);
    push_item(1'b1, COIN_W'($urandom), AMT_W'(5));
    push_item(1'b0, 8'd5, AMT_W'($urandom));
    push_item(1'b0, 8'd10, AMT_W'($urandom));
    push_item(1'b0, 8'd25, AMT_W'($urandom));
    push_item(1'b0, 8'd50, AMT_W'($urandom));
    push_item(1'b0, 8'd100, AMT_W'($urandom));
    push_item(1'b0, 8'd0, AMT_W'($urandom));
    push_item(1'b0, 8'd255, AMT_W'($urandom));
    push_item(1'b0, 8'd1, AMT_W'($urandom));
    push_item(1'b0, 8'd99, AMT_W'($urandom));
    push_item(1'b0, 8'd101, AMT_W'($urandom));
    push_item(1'b0, 8'd20, AMT_W'($urandom));
    push_item(1'b1, COIN_W'($urandom), AMT_W'(190));
    repeat (3) push_item(1'b0, 8'd25, AMT_W'($urandom));
    // 30 from three quarters leaves a nickel short
    push_item(1'b1, COIN_W'($urandom), AMT_W'(30));
    push_item(1'b1, COIN_W'($urandom), AMT_W'(75));
    push_item(1'b1, COIN_W'($urandom), '1);
    push_item(1'b1, COIN_W'($urandom), AMT_W'(7));

    wait_idle();
    push_item(1'b1, COIN_W'($urandom), '1);
    push_item(1'b1, COIN_W'($urandom), '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        idle_on <= (i < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      end
      if (i == RANDOM_ITEMS / 2) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        push_item(1'b0, COIN_W'(coin_pick()), AMT_W'($urandom));
      end else if (pick < 60) begin
        push_item(1'b0, COIN_W'($urandom), AMT_W'($urandom));
      end else if (pick < 78) begin
        push_item(1'b1, COIN_W'($urandom), AMT_W'($urandom_range(0, 60) * 5));
      end else if (pick < 88) begin
        push_item(1'b1, COIN_W'($urandom), AMT_W'($urandom_range(0, 400) * 5));
      end else if (pick < 94) begin
        push_item(1'b1, COIN_W'($urandom), AMT_W'($urandom_range(0, 300)));
      end else begin
        push_item(1'b1, COIN_W'($urandom), AMT_W'($urandom));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
